// ===== rtl/assert_macros.svh =====
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_PROP(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk_sig, rst_sig, prop, msg)
`define ASSERT_NEVER(lbl, clk_sig, rst_sig, cond, msg)

`endif

`endif

// ===== rtl/ptt_pkg.sv =====
package ptt_pkg;

  // parse phases
  localparam logic [3:0] PH_LINE     = 4'd0;
  localparam logic [3:0] PH_COMMENT  = 4'd1;
  localparam logic [3:0] PH_KEY      = 4'd2;
  localparam logic [3:0] PH_KEY_GAP  = 4'd3;
  localparam logic [3:0] PH_VAL_GAP  = 4'd4;
  localparam logic [3:0] PH_VALUE    = 4'd5;
  localparam logic [3:0] PH_ESC      = 4'd6;
  localparam logic [3:0] PH_ESC_CR   = 4'd7;
  localparam logic [3:0] PH_CONT_GAP = 4'd8;
  localparam logic [3:0] PH_HEX      = 4'd9;

  // token kinds
  localparam logic [1:0] KIND_KEY   = 2'd0;
  localparam logic [1:0] KIND_VALUE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_BADU  = 2'd3;

  // characters
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] acc;
    logic [1:0]  cnt;
    logic        open;
  } ptt_state_t;

  typedef struct packed {
    logic        emit;
    logic [1:0]  kind;
    logic [15:0] code;
  } ptt_tok_t;

  // bit 4 set when the byte is a hex digit, low nibble its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ===== rtl/ptt_step.sv =====
module ptt_step (
  input  logic [7:0]          text_byte,
  input  logic                end_of_text,
  input  ptt_pkg::ptt_state_t st,
  output ptt_pkg::ptt_state_t st_next,
  output ptt_pkg::ptt_tok_t   tok
);
  import ptt_pkg::*;

  logic        is_blank;
  logic        is_eol;
  logic        is_sep;
  logic        do_value;
  logic        do_close;
  logic [4:0]  hd;
  logic [15:0] acc_shift;

  assign is_blank  = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
  assign is_eol    = (text_byte == CH_LF) || (text_byte == CH_CR);
  assign is_sep    = (text_byte == CH_EQ) || (text_byte == CH_COLON);
  assign hd        = hex_digit(text_byte);
  assign acc_shift = {st.acc[11:0], hd[3:0]};

  always_comb begin
    st_next  = st;
    tok      = '0;
    do_value = 1'b0;
    do_close = 1'b0;
    if (end_of_text) begin
      if (st.open) begin
        do_close = 1'b1;
      end else begin
        st_next = '0;
      end
    end else begin
      case (st.phase)
        PH_COMMENT: begin
          if (is_eol) st_next.phase = PH_LINE;
        end
        PH_KEY: begin
          if (is_sep) begin
            st_next.phase = PH_VAL_GAP;
          end else if (is_blank) begin
            st_next.phase = PH_KEY_GAP;
          end else if (is_eol) begin
            do_close = 1'b1;
          end else begin
            tok = '{emit: 1'b1, kind: KIND_KEY, code: {8'd0, text_byte}};
          end
        end
        PH_KEY_GAP: begin
          if (is_sep) begin
            st_next.phase = PH_VAL_GAP;
          end else if (!is_blank) begin
            do_value = 1'b1;
          end
        end
        PH_VAL_GAP, PH_CONT_GAP: begin
          if (!is_blank) do_value = 1'b1;
        end
        PH_VALUE: begin
          do_value = 1'b1;
        end
        PH_ESC: begin
          if (text_byte == CH_CR) begin
            st_next.phase = PH_ESC_CR;
          end else if (text_byte == CH_LF) begin
            st_next.phase = PH_CONT_GAP;
          end else if (text_byte == CH_U) begin
            st_next.phase = PH_HEX;
            st_next.acc   = '0;
            st_next.cnt   = '0;
          end else begin
            st_next.phase = PH_VALUE;
            tok.emit = 1'b1;
            tok.kind = KIND_VALUE;
            case (text_byte)
              CH_T:    tok.code = {8'd0, CH_TAB};
              CH_N:    tok.code = {8'd0, CH_LF};
              CH_R:    tok.code = {8'd0, CH_CR};
              default: tok.code = {8'd0, text_byte};
            endcase
          end
        end
        PH_ESC_CR: begin
          if ((text_byte == CH_LF) || is_blank) begin
            st_next.phase = PH_CONT_GAP;
          end else begin
            do_value = 1'b1;
          end
        end
        PH_HEX: begin
          if ((text_byte == CH_U) && (st.cnt == 2'd0)) begin
            st_next = st;
          end else if (is_eol) begin
            do_close = 1'b1;
          end else if (!hd[4]) begin
            // bad digit drops the escape and the byte
            st_next.phase = PH_VALUE;
            st_next.acc   = '0;
            st_next.cnt   = '0;
            tok.emit      = 1'b1;
            tok.kind      = KIND_BADU;
          end else if (st.cnt == 2'd3) begin
            st_next.phase = PH_VALUE;
            st_next.acc   = '0;
            st_next.cnt   = '0;
            tok = '{emit: 1'b1, kind: KIND_VALUE, code: acc_shift};
          end else begin
            st_next.acc = acc_shift;
            st_next.cnt = st.cnt + 2'd1;
          end
        end
        default: begin
          // line start; unused codes land here too
          st_next.phase = PH_LINE;
          if (is_eol || is_blank) begin
            st_next.phase = PH_LINE;
          end else if ((text_byte == CH_HASH) || (text_byte == CH_BANG)) begin
            st_next.phase = PH_COMMENT;
          end else begin
            st_next.open = 1'b1;
            if (is_sep) begin
              st_next.phase = PH_VAL_GAP;
            end else begin
              st_next.phase = PH_KEY;
              tok = '{emit: 1'b1, kind: KIND_KEY, code: {8'd0, text_byte}};
            end
          end
        end
      endcase

      if (do_value) begin
        if (is_eol) begin
          do_close = 1'b1;
        end else if (text_byte == CH_BSL) begin
          st_next.phase = PH_ESC;
        end else begin
          st_next.phase = PH_VALUE;
          tok = '{emit: 1'b1, kind: KIND_VALUE, code: {8'd0, text_byte}};
        end
      end
    end

    if (do_close) begin
      st_next = '0;
      tok = '{emit: 1'b1, kind: KIND_END, code: 16'd0};
    end
  end

endmodule

// ===== rtl/properties_text_tokenizer.sv =====
// a byte accepted into the input register shows its token from the output register
// throughput: one byte per cycle while the output register is empty or taken, as the parse step
// between the input register and the output register is combinational
// bytes that give no token still take one slot of the input register
// reset (rst, synchronous, active high) empties both registers and
// returns the parser to line start with no pair open
`include "assert_macros.svh"

module properties_text_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] char_code
  output logic [1:0]  m_tuser    // [1:0] token_kind
);
  import ptt_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;

  ptt_state_t st;
  ptt_state_t st_next;
  ptt_tok_t   tok;

  logic        out_valid;
  logic [15:0] out_code;
  logic [1:0]  out_kind;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  ptt_step u_step (
    .text_byte   (in_byte),
    .end_of_text (in_last),
    .st          (st),
    .st_next     (st_next),
    .tok         (tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tok.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tok.emit) begin
      out_code <= tok.code;
      out_kind <= tok.kind;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_code;
  assign m_tuser  = out_kind;

  // a pair is open exactly while the parser is inside a key or value
  `ASSERT_PROP(a_open_phase, clk, rst,
    st.open == ((st.phase != PH_LINE) && (st.phase != PH_COMMENT)), "pair flag out of step")
  `ASSERT_PROP(a_hex_count, clk, rst, (st.cnt != 2'd0) |-> (st.phase == PH_HEX),
    "hex digit count outside unicode escape")
  `ASSERT_NEVER(a_phase_range, clk, rst, st.phase > PH_HEX, "unused parse phase")
  `ASSERT_PROP(a_code_zero, clk, rst,
    (m_tvalid && ((m_tuser == KIND_END) || (m_tuser == KIND_BADU))) |-> (m_tdata == 16'd0),
    "pair end or bad escape with nonzero code")

endmodule
